// ===== design/srpm_pkg.sv =====
// Shared types and constants for the sliding-window RMS pan meter.
// No dependencies.
`default_nettype none
package srpm_pkg;

	localparam int unsigned HIST_DEPTH_DEF  = 4096;
	localparam int unsigned SAMPLE_BITS_DEF = 24;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned FIELD_W    = 24;
	localparam int unsigned PAN_W      = 16;
	localparam int unsigned WIN_CFG_W  = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH = 2'd0,
		CFG_PAN_LAW       = 2'd1,
		CFG_DEFAULT_PAN   = 2'd2
	} cfg_reg_t;

	localparam logic [PAN_W-1:0] PAN_FULL        = '1;
	localparam logic [PAN_W-1:0] DEFAULT_PAN_RST = 16'h8000;
	localparam int unsigned      WINDOW_RST      = 1024;

endpackage
`default_nettype wire

// ===== design/srpm_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module srpm_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/sliding_rms_pan_meter.sv =====
// Sliding-window RMS stereo pan meter: top level.
// Depends on srpm_pkg and srpm_ram.
//
// Usage: one stereo pair per input word on s_* (tdata = left, right; tlast =
// end of host block). Each word yields one output word on m_* (tdata = pan,
// unsigned Q0.16; tuser = silent; tlast = copied end of block).
// Configuration: cfg_wr_en with cfg_index (0 window length, 1 pan law,
// 2 default pan) and cfg_data, one write per clock, only while idle.
// Processing: one word at a time. A word goes through the bit-serial
// squaring lanes, then under the linear law through the square-root
// units, and then, unless the window is silent, through the divider.
// Reset, and every write to the window length, clears the histories with a
// sweep over all HIST_DEPTH entries, one entry per cycle; s_tready stays low
// during the sweep. A finished result waits in the output register while the
// receiver stalls; the next word is taken in and worked on meanwhile, and
// its result waits until the register is free.
`default_nettype none
module sliding_rms_pan_meter #(
	parameter int unsigned HIST_DEPTH  = srpm_pkg::HIST_DEPTH_DEF,
	parameter int unsigned SAMPLE_BITS = srpm_pkg::SAMPLE_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [2*srpm_pkg::FIELD_W-1:0]    s_tdata,  // left_sample, right_sample
	input  wire                              s_tlast,  // end_of_block
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [srpm_pkg::PAN_W-1:0]       m_tdata,  // pan
	output logic                             m_tuser,  // silent
	output logic                             m_tlast,  // end_of_block_out
	input  wire                              cfg_wr_en,
	input  wire [srpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [srpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import srpm_pkg::*;

	localparam int unsigned SB     = SAMPLE_BITS;
	localparam int unsigned IDX_W  = $clog2(HIST_DEPTH);
	localparam int unsigned WIN_W  = IDX_W + 1;
	localparam int unsigned SQ_W   = 2 * SB;
	localparam int unsigned SUM_W  = 2 * SB - 1 + IDX_W;
	localparam int unsigned SQ_IT  = (SUM_W + 33) / 2;
	localparam int unsigned RAD_W  = 2 * SQ_IT;
	localparam int unsigned REM_W  = SQ_IT + 2;
	localparam int unsigned D_W    = (SUM_W + 1 > SQ_IT + 1) ? SUM_W + 1 : SQ_IT + 1;
	localparam int unsigned IT_MAX = (SQ_IT > SB) ? ((SQ_IT > PAN_W) ? SQ_IT : PAN_W)
	                                              : ((SB > PAN_W) ? SB : PAN_W);
	localparam int unsigned CNT_W  = $clog2(IT_MAX + 1);
	localparam int unsigned LANES  = 4;
	localparam int unsigned LN_LNEW = 0;
	localparam int unsigned LN_LOLD = 1;
	localparam int unsigned LN_RNEW = 2;
	localparam int unsigned LN_ROLD = 3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_SQUARE, ST_ACCUM, ST_CHECK,
		ST_SQRT, ST_DIV_START, ST_DIV, ST_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WIN_W-1:0]    win_q;
	logic                law_q;
	logic [PAN_W-1:0]    dflt_q;
	logic [IDX_W-1:0]    widx_q;
	logic                clr_q;
	logic [IDX_W-1:0]    clr_addr_q;
	logic [SUM_W-1:0]    lsum_q, rsum_q;
	logic [SB-1:0]       lnew_q, rnew_q;
	logic                eob_q;
	logic [SQ_W-1:0]     mcand_q [LANES];
	logic [SB-1:0]       mplier_q [LANES];
	logic [SQ_W-1:0]     sq_q [LANES];
	logic [RAD_W-1:0]    lrad_q, rrad_q;
	logic [REM_W-1:0]    lrem_q, rrem_q;
	logic [SQ_IT-1:0]    lroot_q, rroot_q;
	logic [D_W-1:0]      num_q, den_q;
	logic [D_W:0]        drem_q;
	logic [PAN_W-1:0]    quo_q;
	logic [PAN_W-1:0]    pan_q;
	logic                silent_q;

	logic [31:0]         in_l32, in_r32, win_req;
	logic [SB-1:0]       in_l, in_r;
	logic [SB-1:0]       lold, rold;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [SB-1:0]       ram_lw, ram_rw;
	logic                accept, win_wr, out_free;
	logic [REM_W-1:0]    lrem_n, rrem_n, ltrial, rtrial;
	logic [SQ_IT-1:0]    lroot_n, rroot_n;
	logic [D_W:0]        drem_n;

	function automatic logic [SB-1:0] mag_of(input logic [SB-1:0] v);
		return v[SB-1] ? SB'(-v) : v;
	endfunction

	assign in_l32  = {8'd0, s_tdata[FIELD_W-1:0]};
	assign in_r32  = {8'd0, s_tdata[2*FIELD_W-1:FIELD_W]};
	assign in_l    = in_l32[SB-1:0];
	assign in_r    = in_r32[SB-1:0];
	assign win_req = {19'd0, cfg_data[WIN_CFG_W-1:0]};

	assign s_tready = (state_q == ST_IDLE) && !clr_q;
	assign accept   = s_tvalid && s_tready;
	assign win_wr   = cfg_wr_en && (cfg_index == CFG_WINDOW_LENGTH);
	assign out_free = !m_tvalid || m_tready;

	assign ram_we    = clr_q || (state_q == ST_FETCH);
	assign ram_waddr = clr_q ? clr_addr_q : widx_q;
	assign ram_lw    = clr_q ? '0 : lnew_q;
	assign ram_rw    = clr_q ? '0 : rnew_q;

	srpm_ram #(.WIDTH(SB), .DEPTH(HIST_DEPTH)) u_left_hist (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_lw),
		.raddr(widx_q), .rdata(lold)
	);
	srpm_ram #(.WIDTH(SB), .DEPTH(HIST_DEPTH)) u_right_hist (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_rw),
		.raddr(widx_q), .rdata(rold)
	);

	assign lrem_n  = {lrem_q[REM_W-3:0], lrad_q[RAD_W-1 -: 2]};
	assign rrem_n  = {rrem_q[REM_W-3:0], rrad_q[RAD_W-1 -: 2]};
	assign ltrial  = {lroot_q, 2'b01};
	assign rtrial  = {rroot_q, 2'b01};
	assign lroot_n = {lroot_q[SQ_IT-2:0], lrem_n >= ltrial};
	assign rroot_n = {rroot_q[SQ_IT-2:0], rrem_n >= rtrial};
	assign drem_n  = {drem_q[D_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			win_q      <= WIN_W'(WINDOW_RST);
			law_q      <= 1'b0;
			dflt_q     <= DEFAULT_PAN_RST;
			widx_q     <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			lsum_q     <= '0;
			rsum_q     <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && (state_q != ST_DONE)) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_WINDOW_LENGTH: begin
						if (win_req == 32'd0) begin
							win_q <= WIN_W'(1);
						end else if (win_req > HIST_DEPTH) begin
							win_q <= WIN_W'(HIST_DEPTH);
						end else begin
							win_q <= win_req[WIN_W-1:0];
						end
					end
					CFG_PAN_LAW:     law_q  <= cfg_data[0];
					CFG_DEFAULT_PAN: dflt_q <= cfg_data[PAN_W-1:0];
					default: ;
				endcase
			end
			if (win_wr) begin
				clr_q      <= 1'b1;
				clr_addr_q <= '0;
				lsum_q     <= '0;
				rsum_q     <= '0;
				widx_q     <= '0;
			end else if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == IDX_W'(HIST_DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lnew_q  <= in_l;
						rnew_q  <= in_r;
						eob_q   <= s_tlast;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					mplier_q[LN_LNEW] <= mag_of(lnew_q);
					mplier_q[LN_LOLD] <= mag_of(lold);
					mplier_q[LN_RNEW] <= mag_of(rnew_q);
					mplier_q[LN_ROLD] <= mag_of(rold);
					mcand_q[LN_LNEW]  <= SQ_W'(mag_of(lnew_q));
					mcand_q[LN_LOLD]  <= SQ_W'(mag_of(lold));
					mcand_q[LN_RNEW]  <= SQ_W'(mag_of(rnew_q));
					mcand_q[LN_ROLD]  <= SQ_W'(mag_of(rold));
					for (int i = 0; i < LANES; i++) begin
						sq_q[i] <= '0;
					end
					cnt_q   <= '0;
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					for (int i = 0; i < LANES; i++) begin
						if (mplier_q[i][0]) begin
							sq_q[i] <= sq_q[i] + mcand_q[i];
						end
						mcand_q[i]  <= {mcand_q[i][SQ_W-2:0], 1'b0};
						mplier_q[i] <= {1'b0, mplier_q[i][SB-1:1]};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SB - 1)) begin
						state_q <= ST_ACCUM;
					end
				end
				ST_ACCUM: begin
					lsum_q <= lsum_q + SUM_W'(sq_q[LN_LNEW]) - SUM_W'(sq_q[LN_LOLD]);
					rsum_q <= rsum_q + SUM_W'(sq_q[LN_RNEW]) - SUM_W'(sq_q[LN_ROLD]);
					if (WIN_W'(widx_q) + 1'b1 >= win_q) begin
						widx_q <= '0;
					end else begin
						widx_q <= widx_q + 1'b1;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (lsum_q == '0 && rsum_q == '0) begin
						pan_q    <= dflt_q;
						silent_q <= 1'b1;
						state_q  <= ST_DONE;
					end else if (!law_q) begin
						silent_q <= 1'b0;
						num_q    <= D_W'(rsum_q);
						den_q    <= D_W'(lsum_q) + D_W'(rsum_q);
						state_q  <= ST_DIV_START;
					end else begin
						silent_q <= 1'b0;
						lrad_q   <= {(RAD_W-32)'(lsum_q), 32'd0};
						rrad_q   <= {(RAD_W-32)'(rsum_q), 32'd0};
						lrem_q   <= '0;
						rrem_q   <= '0;
						lroot_q  <= '0;
						rroot_q  <= '0;
						state_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					lrad_q <= {lrad_q[RAD_W-3:0], 2'b00};
					rrad_q <= {rrad_q[RAD_W-3:0], 2'b00};
					if (lrem_n >= ltrial) begin
						lrem_q  <= lrem_n - ltrial;
						lroot_q <= {lroot_q[SQ_IT-2:0], 1'b1};
					end else begin
						lrem_q  <= lrem_n;
						lroot_q <= {lroot_q[SQ_IT-2:0], 1'b0};
					end
					if (rrem_n >= rtrial) begin
						rrem_q  <= rrem_n - rtrial;
						rroot_q <= {rroot_q[SQ_IT-2:0], 1'b1};
					end else begin
						rrem_q  <= rrem_n;
						rroot_q <= {rroot_q[SQ_IT-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQ_IT - 1)) begin
						state_q <= ST_DIV_START;
						num_q   <= D_W'(rroot_n);
						den_q   <= D_W'(lroot_n) + D_W'(rroot_n);
					end
				end
				ST_DIV_START: begin
					cnt_q  <= '0;
					drem_q <= {1'b0, num_q};
					quo_q  <= '0;
					if (num_q >= den_q) begin
						pan_q   <= PAN_FULL;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (drem_n >= {1'b0, den_q}) begin
						drem_q <= drem_n - {1'b0, den_q};
						quo_q  <= {quo_q[PAN_W-2:0], 1'b1};
					end else begin
						drem_q <= drem_n;
						quo_q  <= {quo_q[PAN_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PAN_W - 1)) begin
						state_q <= ST_DONE;
						pan_q   <= (drem_n >= {1'b0, den_q}) ? {quo_q[PAN_W-2:0], 1'b1}
						                                     : {quo_q[PAN_W-2:0], 1'b0};
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= pan_q;
						m_tuser  <= silent_q;
						m_tlast  <= eob_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idx_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		WIN_W'(widx_q) < win_q)
		else $error("write index outside window");
	a_accept_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_FETCH))
		else $error("accepted word did not start fetch");
	a_sqrt_linear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> law_q)
		else $error("square root run under equal-power law");
	a_no_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s_tready)
		else $error("word taken during history clear");
`endif

endmodule
`default_nettype wire
